// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, prop)

`endif

`endif

// ===== rtl/core/dpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcr_pkg
// Shared constants and types of the clock replacement paging block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpcr_pkg;

   localparam int PAGE_BYTES        = 256;
   localparam int PAGES_PER_PROCESS = 8;
   localparam int PROCESS_SLOTS     = 5;
   localparam int FRAME_SLOTS       = 12;

   localparam int OFF_W   = 8;
   localparam int PAGE_W  = 3;
   localparam int PID_W   = 3;
   localparam int FRAME_W = 4;
   localparam int ROW_W   = PID_W + PAGE_W;
   localparam int CNT_W   = OFF_W + 1;

   localparam int FRAME_MEM_DEPTH = FRAME_SLOTS * PAGE_BYTES;
   localparam int DISK_MEM_DEPTH  = PROCESS_SLOTS * PAGES_PER_PROCESS * PAGE_BYTES;
   localparam int DISK_ROWS       = PROCESS_SLOTS * PAGES_PER_PROCESS;

   localparam logic [7:0] DISK_PROC_MUL = 8'd53;
   localparam logic [7:0] DISK_PAGE_MUL = 8'd31;
   localparam logic [7:0] DISK_BYTE_MUL = 8'd17;
   localparam logic [7:0] DISK_BIAS     = 8'h42;

   localparam logic [3:0] FRAMES_RESET = 4'd8;
   localparam logic [2:0] PROCS_RESET  = 3'd5;
   localparam logic [2:0] PAGES_RESET  = 3'd4;

   localparam logic [2:0] CSR_FRAMES  = 3'd0;
   localparam logic [2:0] CSR_PROCS   = 3'd1;
   localparam logic [2:0] CSR_PAGES_1 = 3'd2;
   localparam logic [2:0] CSR_PAGES_5 = 3'd6;

   typedef enum logic [2:0] {
      OUT_HIT         = 3'd0,
      OUT_MISS_FREE   = 3'd1,
      OUT_MISS_CLEAN  = 3'd2,
      OUT_MISS_DIRTY  = 3'd3,
      OUT_KILLED      = 3'd4,
      OUT_DEAD        = 3'd5
   } outcome_type;

   typedef struct packed {
      logic              en;
      logic [ROW_W-1:0]  row;
      logic [OFF_W-1:0]  idx;
      logic [7:0]        data;
   } disk_wr_type;

endpackage

// ===== rtl/core/dpcr_ram.sv =====
// ----------------------------------------------------------------------------
// dpcr_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpcr_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dpcr_disk.sv =====
// ----------------------------------------------------------------------------
// dpcr_disk
// Backing store; rows never written read their power-up pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpcr_disk (
   input  logic                      clock,
   input  logic                      reset,
   input  dpcr_pkg::disk_wr_type     wr,
   input  logic [dpcr_pkg::ROW_W-1:0] rd_row,
   input  logic [dpcr_pkg::OFF_W-1:0] rd_idx,
   output logic [7:0]                rd_data
);

   localparam int AW = $clog2(dpcr_pkg::DISK_MEM_DEPTH);

   logic             written_ff [dpcr_pkg::DISK_ROWS];
   logic             hit_written_ff;
   logic [7:0]       pattern_ff;
   logic [7:0]       pattern_in;
   logic [7:0]       mem_data;

   always_comb begin
      pattern_in = 8'((8'(rd_row[dpcr_pkg::ROW_W-1:dpcr_pkg::PAGE_W]) + 8'd1)
                      * dpcr_pkg::DISK_PROC_MUL
                    + 8'(rd_row[dpcr_pkg::PAGE_W-1:0]) * dpcr_pkg::DISK_PAGE_MUL
                    + rd_idx * dpcr_pkg::DISK_BYTE_MUL
                    + dpcr_pkg::DISK_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dpcr_pkg::DISK_ROWS; i++) begin
            written_ff[i] <= 1'b0;
         end
      end else if (wr.en) begin
         written_ff[wr.row] <= 1'b1;
      end
      hit_written_ff <= written_ff[rd_row];
      pattern_ff     <= pattern_in;
   end

   dpcr_ram #(
      .DEPTH (dpcr_pkg::DISK_MEM_DEPTH),
      .WIDTH (8)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (AW'({wr.row, wr.idx})),
      .wr_data (wr.data),
      .rd_addr (AW'({rd_row, rd_idx})),
      .rd_data (mem_data)
   );

   assign rd_data = hit_written_ff ? mem_data : pattern_ff;

endmodule

// ===== rtl/core/demand_paging_clock_replacement.sv =====
// ----------------------------------------------------------------------------
// demand_paging_clock_replacement
// Demand paged byte memory with clock (second chance) frame replacement.
// ----------------------------------------------------------------------------
// One access at a time. A word for an unknown or dead process is answered on
// rsp_valid the cycle after start without raising busy. Any other word raises
// busy the cycle after start, and busy falls when the result strobe rsp_valid
// is raised for its single cycle; the receiver cannot stall it. A hit passes
// through ST_ACC and ST_WAIT. A miss adds one ST_SWEEP step per frame the
// clock hand visits (up to the effective frame count + 1), a page load and,
// for a dirty victim, a write back before it, since each page moves one byte
// a cycle through the frame and disk memory ports. A kill scans the 12
// frames, one a cycle while no copy runs, and for each dirty frame of the
// process copies it to disk and then rescans it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module demand_paging_clock_replacement (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_process_id,
   input  logic        req_is_write,
   input  logic [2:0]  req_page_number,
   input  logic [7:0]  req_byte_offset,
   input  logic [7:0]  req_write_byte,
   output logic        rsp_valid,
   output logic [2:0]  rsp_outcome,
   output logic [3:0]  rsp_frame_used,
   output logic [11:0] rsp_physical_address,
   output logic [7:0]  rsp_read_byte,
   output logic [2:0]  rsp_victim_process,
   output logic [2:0]  rsp_victim_page,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int NF  = dpcr_pkg::FRAME_SLOTS;
   localparam int NP  = dpcr_pkg::PROCESS_SLOTS;
   localparam int FW  = dpcr_pkg::FRAME_W;
   localparam int CW  = dpcr_pkg::CNT_W;
   localparam int FAW = $clog2(dpcr_pkg::FRAME_MEM_DEPTH);
   localparam logic [FW-1:0] LAST_FRAME = FW'(NF - 1);
   localparam logic [CW-1:0] CNT_END    = CW'(dpcr_pkg::PAGE_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_KILL_SCAN, ST_KILL_COPY, ST_SWEEP, ST_EVICT_COPY, ST_LOAD,
      ST_ACC, ST_WAIT
   } state_type;

   state_type state_ff;

   logic [3:0] frames_ff;
   logic [2:0] procs_ff;
   logic [2:0] pages_ff [NP];
   logic       alive_ff [NP];

   logic          fvalid_ff [NF];
   logic          fmod_ff   [NF];
   logic [2:0]    fowner_ff [NF];
   logic [2:0]    fpage_ff  [NF];
   logic          fref_ff   [NF];
   logic [FW-1:0] hand_ff;

   logic [2:0]    pid_ff;
   logic [2:0]    slot_ff;
   logic          wr_ff;
   logic [2:0]    page_ff;
   logic [7:0]    off_ff;
   logic [7:0]    val_ff;
   logic [FW-1:0] vf_ff;
   logic [CW-1:0] cnt_ff;
   logic [5:0]    dst_row_ff;

   dpcr_pkg::outcome_type outcome_ff;
   logic [2:0]    vproc_ff;
   logic [2:0]    vpage_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_outcome_ff;
   logic [3:0]    rsp_frame_ff;
   logic [11:0]   rsp_addr_ff;
   logic [7:0]    rsp_byte_ff;
   logic [2:0]    rsp_vproc_ff;
   logic [2:0]    rsp_vpage_ff;

   logic [FW-1:0] m_eff;
   logic [2:0]    np_eff;
   logic [2:0]    req_slot;
   logic          req_live;
   logic          req_kill;
   logic          hit;
   logic [FW-1:0] hit_frame;
   logic [FW-1:0] hand_nx;
   logic          cnt_busy;
   logic [7:0]    cnt_prev;
   logic          rsp_fault;

   logic            fr_we;
   logic [FAW-1:0]  fr_waddr;
   logic [7:0]      fr_wdata;
   logic [FAW-1:0]  fr_raddr;
   logic [7:0]      fr_rdata;
   dpcr_pkg::disk_wr_type disk_wr;
   logic [7:0]      disk_rdata;

   always_comb begin
      if (frames_ff < 4'd2) begin
         m_eff = 4'd2;
      end else if (frames_ff > 4'(NF)) begin
         m_eff = 4'(NF);
      end else begin
         m_eff = frames_ff;
      end
      if (procs_ff == 3'd0) begin
         np_eff = 3'd1;
      end else if (procs_ff > 3'(NP)) begin
         np_eff = 3'(NP);
      end else begin
         np_eff = procs_ff;
      end
      req_slot = req_process_id - 3'd1;
      req_live = 1'b0;
      req_kill = 1'b0;
      if (req_process_id != 3'd0 && req_process_id <= np_eff) begin
         req_live = alive_ff[req_slot];
         req_kill = req_page_number >= pages_ff[req_slot];
      end
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = 0; i < NF; i++) begin
         if (fvalid_ff[i] && fowner_ff[i] == req_process_id
             && fpage_ff[i] == req_page_number) begin
            hit       = 1'b1;
            hit_frame = FW'(i);
         end
      end
      hand_nx  = (hand_ff + FW'(1) == m_eff) ? '0 : hand_ff + FW'(1);
      cnt_busy = cnt_ff != '0;
      cnt_prev = 8'(cnt_ff - CW'(1));
   end

   // memory port steering
   always_comb begin
      fr_raddr = FAW'({vf_ff, cnt_ff[7:0]});
      fr_we    = 1'b0;
      fr_waddr = FAW'({vf_ff, off_ff});
      fr_wdata = val_ff;
      disk_wr.en   = 1'b0;
      disk_wr.row  = dst_row_ff;
      disk_wr.idx  = cnt_prev;
      disk_wr.data = fr_rdata;
      unique case (state_ff)
         ST_KILL_COPY, ST_EVICT_COPY: begin
            disk_wr.en = cnt_busy;
         end
         ST_LOAD: begin
            fr_we    = cnt_busy;
            fr_waddr = FAW'({vf_ff, cnt_prev});
            fr_wdata = disk_rdata;
         end
         ST_ACC: begin
            fr_raddr = FAW'({vf_ff, off_ff});
            fr_we    = wr_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= dpcr_pkg::FRAMES_RESET;
         procs_ff     <= dpcr_pkg::PROCS_RESET;
         hand_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NP; p++) begin
            pages_ff[p] <= dpcr_pkg::PAGES_RESET;
            alive_ff[p] <= 1'b1;
         end
         for (int i = 0; i < NF; i++) begin
            fvalid_ff[i] <= 1'b0;
            fmod_ff[i]   <= 1'b0;
            fowner_ff[i] <= '0;
            fpage_ff[i]  <= '0;
            fref_ff[i]   <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == dpcr_pkg::CSR_FRAMES) begin
               frames_ff <= csr_wdata;
            end else if (csr_index == dpcr_pkg::CSR_PROCS) begin
               procs_ff <= csr_wdata[2:0];
            end else if (csr_index >= dpcr_pkg::CSR_PAGES_1
                         && csr_index <= dpcr_pkg::CSR_PAGES_5) begin
               pages_ff[3'(csr_index - dpcr_pkg::CSR_PAGES_1)] <= csr_wdata[2:0];
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  pid_ff     <= req_process_id;
                  slot_ff    <= req_slot;
                  wr_ff      <= req_is_write;
                  page_ff    <= req_page_number;
                  off_ff     <= req_byte_offset;
                  val_ff     <= req_write_byte;
                  vproc_ff   <= '0;
                  vpage_ff   <= '0;
                  cnt_ff     <= '0;
                  outcome_ff <= dpcr_pkg::OUT_HIT;
                  if (!req_live) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_outcome_ff <= dpcr_pkg::OUT_DEAD;
                     rsp_frame_ff   <= '0;
                     rsp_addr_ff    <= '0;
                     rsp_byte_ff    <= '0;
                     rsp_vproc_ff   <= '0;
                     rsp_vpage_ff   <= '0;
                  end else if (req_kill) begin
                     alive_ff[req_slot] <= 1'b0;
                     vf_ff    <= '0;
                     state_ff <= ST_KILL_SCAN;
                  end else if (hit) begin
                     vf_ff    <= hit_frame;
                     state_ff <= ST_ACC;
                  end else begin
                     if (hand_ff >= m_eff) begin
                        hand_ff <= '0;
                     end
                     state_ff <= ST_SWEEP;
                  end
               end
            end
            ST_KILL_SCAN: begin
               if (fvalid_ff[vf_ff] && fowner_ff[vf_ff] == pid_ff && fmod_ff[vf_ff]) begin
                  dst_row_ff <= {slot_ff, fpage_ff[vf_ff]};
                  cnt_ff     <= '0;
                  state_ff   <= ST_KILL_COPY;
               end else begin
                  if (fvalid_ff[vf_ff] && fowner_ff[vf_ff] == pid_ff) begin
                     fvalid_ff[vf_ff] <= 1'b0;
                     fmod_ff[vf_ff]   <= 1'b0;
                     fowner_ff[vf_ff] <= '0;
                     fpage_ff[vf_ff]  <= '0;
                     fref_ff[vf_ff]   <= 1'b0;
                  end
                  if (vf_ff == LAST_FRAME) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_outcome_ff <= dpcr_pkg::OUT_KILLED;
                     rsp_frame_ff   <= '0;
                     rsp_addr_ff    <= '0;
                     rsp_byte_ff    <= '0;
                     rsp_vproc_ff   <= '0;
                     rsp_vpage_ff   <= '0;
                     state_ff       <= ST_IDLE;
                  end else begin
                     vf_ff <= vf_ff + FW'(1);
                  end
               end
            end
            ST_KILL_COPY: begin
               if (cnt_ff == CNT_END) begin
                  cnt_ff         <= '0;
                  fmod_ff[vf_ff] <= 1'b0;
                  state_ff       <= ST_KILL_SCAN;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_SWEEP: begin
               hand_ff <= hand_nx;
               if (!fvalid_ff[hand_ff] || !fref_ff[hand_ff]) begin
                  vf_ff  <= hand_ff;
                  cnt_ff <= '0;
                  if (fvalid_ff[hand_ff]) begin
                     vproc_ff   <= fowner_ff[hand_ff];
                     vpage_ff   <= fpage_ff[hand_ff];
                     dst_row_ff <= {3'(fowner_ff[hand_ff] - 3'd1), fpage_ff[hand_ff]};
                     if (fmod_ff[hand_ff]) begin
                        outcome_ff <= dpcr_pkg::OUT_MISS_DIRTY;
                        state_ff   <= ST_EVICT_COPY;
                     end else begin
                        outcome_ff <= dpcr_pkg::OUT_MISS_CLEAN;
                        state_ff   <= ST_LOAD;
                     end
                  end else begin
                     outcome_ff <= dpcr_pkg::OUT_MISS_FREE;
                     state_ff   <= ST_LOAD;
                  end
               end else begin
                  fref_ff[hand_ff] <= 1'b0;
               end
            end
            ST_EVICT_COPY: begin
               if (cnt_ff == CNT_END) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_LOAD;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_LOAD: begin
               if (cnt_ff == CNT_END) begin
                  cnt_ff           <= '0;
                  fvalid_ff[vf_ff] <= 1'b1;
                  fmod_ff[vf_ff]   <= 1'b0;
                  fowner_ff[vf_ff] <= pid_ff;
                  fpage_ff[vf_ff]  <= page_ff;
                  state_ff         <= ST_ACC;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_ACC: begin
               fref_ff[vf_ff] <= 1'b1;
               if (wr_ff) begin
                  fmod_ff[vf_ff] <= 1'b1;
               end
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               rsp_valid_ff   <= 1'b1;
               rsp_outcome_ff <= outcome_ff;
               rsp_frame_ff   <= vf_ff;
               rsp_addr_ff    <= 12'({vf_ff, off_ff});
               rsp_byte_ff    <= wr_ff ? val_ff : fr_rdata;
               rsp_vproc_ff   <= vproc_ff;
               rsp_vpage_ff   <= vpage_ff;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   dpcr_ram #(
      .DEPTH (dpcr_pkg::FRAME_MEM_DEPTH),
      .WIDTH (8)
   ) u_frames (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   dpcr_disk u_disk (
      .clock   (clock),
      .reset   (reset),
      .wr      (disk_wr),
      .rd_row  ({slot_ff, page_ff}),
      .rd_idx  (cnt_ff[7:0]),
      .rd_data (disk_rdata)
   );

   assign busy                 = state_ff != ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_frame_used       = rsp_frame_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_read_byte        = rsp_byte_ff;
   assign rsp_victim_process   = rsp_vproc_ff;
   assign rsp_victim_page      = rsp_vpage_ff;
   assign rsp_fault            = rsp_valid && rsp_outcome >= dpcr_pkg::OUT_KILLED;

   `ASSERT_NEVER(a_busy_strobe, clock, reset, rsp_valid && busy)
   `ASSERT_NEVER(a_hand_range, clock, reset, hand_ff >= FW'(NF))
   `ASSERT_NEVER(a_fault_fields, clock, reset, rsp_fault && rsp_frame_used != 4'd0)
   `ASSERT_NEVER(a_copy_count, clock, reset, cnt_ff > CNT_END)

endmodule

// ===== sim/dpcr_checker.sv =====
// ----------------------------------------------------------------------------
// dpcr_checker
// Watches the access and config ports of the paging block, keeps its own copy
// of the frame, disk and clock hand state, and compares every response word
// field by field with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpcr_checker
   import dpcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_process_id,
   input  logic        req_is_write,
   input  logic [2:0]  req_page_number,
   input  logic [7:0]  req_byte_offset,
   input  logic [7:0]  req_write_byte,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_outcome,
   input  logic [3:0]  rsp_frame_used,
   input  logic [11:0] rsp_physical_address,
   input  logic [7:0]  rsp_read_byte,
   input  logic [2:0]  rsp_victim_process,
   input  logic [2:0]  rsp_victim_page,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   output int          pending,
   output int          mismatches
);

   typedef struct {
      outcome_type outcome;
      logic [3:0]  frame;
      logic [11:0] addr;
      logic [7:0]  rdata;
      logic [2:0]  vproc;
      logic [2:0]  vpage;
   } access_word_type;

   access_word_type expected_words[$];

   logic [3:0] frames_reg;
   logic [2:0] procs_reg;
   logic [2:0] pages_reg [PROCESS_SLOTS];

   logic [7:0] frame_mem [FRAME_SLOTS][PAGE_BYTES];
   logic [7:0] disk_mem  [PROCESS_SLOTS][PAGES_PER_PROCESS][PAGE_BYTES];
   logic       f_valid [FRAME_SLOTS];
   logic       f_dirty [FRAME_SLOTS];
   logic [2:0] f_owner [FRAME_SLOTS];
   logic [2:0] f_page  [FRAME_SLOTS];
   logic       f_ref   [FRAME_SLOTS];
   int         hand;
   logic       resident [PROCESS_SLOTS][PAGES_PER_PROCESS];
   logic [3:0] mapped   [PROCESS_SLOTS][PAGES_PER_PROCESS];
   logic       alive    [PROCESS_SLOTS];

   task automatic clear_model();
      for (int p = 0; p < PROCESS_SLOTS; p++) begin
         pages_reg[p] = PAGES_RESET;
         alive[p] = 1'b1;
         for (int pg = 0; pg < PAGES_PER_PROCESS; pg++) begin
            resident[p][pg] = 1'b0;
            mapped[p][pg] = '0;
            for (int b = 0; b < PAGE_BYTES; b++)
               disk_mem[p][pg][b] = 8'((p + 1) * DISK_PROC_MUL + pg * DISK_PAGE_MUL
                                       + b * DISK_BYTE_MUL + DISK_BIAS);
         end
      end
      for (int f = 0; f < FRAME_SLOTS; f++) begin
         f_valid[f] = 1'b0;
         f_dirty[f] = 1'b0;
         f_owner[f] = '0;
         f_page[f]  = '0;
         f_ref[f]   = 1'b0;
         for (int b = 0; b < PAGE_BYTES; b++)
            frame_mem[f][b] = '0;
      end
      frames_reg = FRAMES_RESET;
      procs_reg  = PROCS_RESET;
      hand = 0;
   endtask

   task automatic flush_frame(input int f);
      int o;
      int pg;
      o  = f_owner[f];
      pg = f_page[f];
      if (o >= 1 && o <= PROCESS_SLOTS) begin
         if (f_dirty[f])
            for (int b = 0; b < PAGE_BYTES; b++)
               disk_mem[o-1][pg][b] = frame_mem[f][b];
         resident[o-1][pg] = 1'b0;
         mapped[o-1][pg] = '0;
      end
   endtask

   task automatic terminate(input int slot);
      alive[slot] = 1'b0;
      for (int f = 0; f < FRAME_SLOTS; f++) begin
         if (f_valid[f] && f_owner[f] == slot + 1) begin
            flush_frame(f);
            f_valid[f] = 1'b0;
            f_dirty[f] = 1'b0;
            f_owner[f] = '0;
            f_page[f]  = '0;
            f_ref[f]   = 1'b0;
            for (int b = 0; b < PAGE_BYTES; b++)
               frame_mem[f][b] = '0;
         end
      end
      for (int pg = 0; pg < PAGES_PER_PROCESS; pg++) begin
         resident[slot][pg] = 1'b0;
         mapped[slot][pg] = '0;
      end
   endtask

   function automatic int sweep_victim();
      int m;
      int h;
      m = frames_reg < 2 ? 2 : (frames_reg > FRAME_SLOTS ? FRAME_SLOTS : frames_reg);
      if (hand >= m)
         hand = 0;
      forever begin
         h = hand;
         hand = (h + 1) % m;
         if (!f_valid[h] || !f_ref[h])
            return h;
         f_ref[h] = 1'b0;
      end
   endfunction

   task automatic predict_access(output access_word_type w);
      int nproc;
      int npages;
      int slot;
      int pg;
      int off;
      int f;
      w = '{OUT_HIT, '0, '0, '0, '0, '0};
      nproc = procs_reg < 1 ? 1 : (procs_reg > PROCESS_SLOTS ? PROCESS_SLOTS : procs_reg);
      if (req_process_id < 1 || req_process_id > nproc || !alive[req_process_id-1]) begin
         w.outcome = OUT_DEAD;
         return;
      end
      slot = req_process_id - 1;
      pg   = req_page_number;
      off  = req_byte_offset;
      npages = pages_reg[slot] > PAGES_PER_PROCESS ? PAGES_PER_PROCESS : pages_reg[slot];
      if (pg >= npages) begin
         terminate(slot);
         w.outcome = OUT_KILLED;
         return;
      end
      if (!resident[slot][pg]) begin
         f = sweep_victim();
         if (f_valid[f]) begin
            w.outcome = f_dirty[f] ? OUT_MISS_DIRTY : OUT_MISS_CLEAN;
            w.vproc = f_owner[f];
            w.vpage = f_page[f];
            flush_frame(f);
         end else begin
            w.outcome = OUT_MISS_FREE;
         end
         f_valid[f] = 1'b1;
         f_dirty[f] = 1'b0;
         f_owner[f] = req_process_id;
         f_page[f]  = pg;
         for (int b = 0; b < PAGE_BYTES; b++)
            frame_mem[f][b] = disk_mem[slot][pg][b];
         resident[slot][pg] = 1'b1;
         mapped[slot][pg] = f;
      end
      f = mapped[slot][pg];
      f_ref[f] = 1'b1;
      if (req_is_write) begin
         frame_mem[f][off] = req_write_byte;
         f_dirty[f] = 1'b1;
      end
      w.frame = f;
      w.addr  = 12'(f * PAGE_BYTES + off);
      w.rdata = frame_mem[f][off];
   endtask

   task automatic compare_word();
      access_word_type w;
      if (expected_words.size() == 0) begin
         $error("response word with nothing expected");
         mismatches++;
         return;
      end
      w = expected_words.pop_front();
      if (rsp_outcome !== w.outcome) begin
         $error("outcome expected %0d got %0d", w.outcome, rsp_outcome);
         mismatches++;
      end
      if (rsp_frame_used !== w.frame) begin
         $error("frame_used expected %0d got %0d", w.frame, rsp_frame_used);
         mismatches++;
      end
      if (rsp_physical_address !== w.addr) begin
         $error("physical_address expected %0d got %0d", w.addr, rsp_physical_address);
         mismatches++;
      end
      if (rsp_read_byte !== w.rdata) begin
         $error("read_byte expected %0d got %0d", w.rdata, rsp_read_byte);
         mismatches++;
      end
      if (rsp_victim_process !== w.vproc) begin
         $error("victim_process expected %0d got %0d", w.vproc, rsp_victim_process);
         mismatches++;
      end
      if (rsp_victim_page !== w.vpage) begin
         $error("victim_page expected %0d got %0d", w.vpage, rsp_victim_page);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      access_word_type w;
      if (reset) begin
         clear_model();
         expected_words.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FRAMES)
               frames_reg = csr_wdata;
            else if (csr_index == CSR_PROCS)
               procs_reg = csr_wdata[2:0];
            else if (csr_index >= CSR_PAGES_1 && csr_index <= CSR_PAGES_5)
               pages_reg[csr_index - CSR_PAGES_1] = csr_wdata[2:0];
         end
         if (rsp_valid)
            compare_word();
         if (start && !busy) begin
            predict_access(w);
            expected_words.push_back(w);
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the paging block with directed and random byte accesses under
// several frame, process and page allocation settings, with bursty traffic,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dpcr_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_process_id = '0;
   logic        req_is_write = 1'b0;
   logic [2:0]  req_page_number = '0;
   logic [7:0]  req_byte_offset = '0;
   logic [7:0]  req_write_byte = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_outcome;
   logic [3:0]  rsp_frame_used;
   logic [11:0] rsp_physical_address;
   logic [7:0]  rsp_read_byte;
   logic [2:0]  rsp_victim_process;
   logic [2:0]  rsp_victim_page;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [3:0]  csr_wdata = '0;
   int          pending;
   int          mismatches;
   int          cycles = 0;

   bit feeding = 0;
   int burst_left = 1;
   int procs_eff = 5;
   int pages_eff [PROCESS_SLOTS] = '{4, 4, 4, 4, 4};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   demand_paging_clock_replacement u_dut (.*);

   dpcr_checker u_checker (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic stop_start();
      if (feeding) begin
         start <= 1'b0;
         feeding = 0;
      end
   endtask

   task automatic drain();
      stop_start();
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic send_word(input logic [2:0] pid, input logic wr, input logic [2:0] pg,
                            input logic [7:0] off, input logic [7:0] val);
      bit ok;
      req_process_id  <= pid;
      req_is_write    <= wr;
      req_page_number <= pg;
      req_byte_offset <= off;
      req_write_byte  <= val;
      start <= 1'b1;
      feeding = 1;
      do begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end while (!ok);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         feeding = 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int frames, input int procs, input int p1,
                                input int p2, input int p3, input int p4, input int p5);
      int pg [PROCESS_SLOTS];
      pg = '{p1, p2, p3, p4, p5};
      drain();
      write_reg(CSR_FRAMES, 4'(frames));
      write_reg(CSR_PROCS, 4'(procs));
      for (int i = 0; i < PROCESS_SLOTS; i++) begin
         write_reg(CSR_PAGES_1 + 3'(i), 4'(pg[i]));
         pages_eff[i] = pg[i] > PAGES_PER_PROCESS ? PAGES_PER_PROCESS : pg[i];
      end
      procs_eff = procs < 1 ? 1 : (procs > PROCESS_SLOTS ? PROCESS_SLOTS : procs);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_words(input int n, input bit allow_kill);
      int r;
      logic [2:0] pid;
      logic [2:0] pg;
      logic [7:0] off;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2)
            drain();
         r = $urandom_range(0, 99);
         pid = 3'($urandom_range(1, procs_eff));
         pg  = 3'($urandom_range(0, pages_eff[pid-1] - 1));
         off = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         if (r < 8) begin
            case ($urandom_range(0, 2))
               0: pid = 3'd0;
               1: pid = 3'($urandom_range(6, 7));
               default: pid = procs_eff < 7 ? 3'($urandom_range(procs_eff + 1, 7)) : 3'd7;
            endcase
            pg = 3'($urandom);
         end else if (allow_kill && r < 11 && pages_eff[pid-1] < PAGES_PER_PROCESS) begin
            pg = 3'($urandom_range(pages_eff[pid-1], 7));
         end
         send_word(pid, 1'($urandom), pg, off, 8'($urandom));
      end
      stop_start();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_setting(2, 5, 4, 4, 4, 4, 4);
      send_word(3'd1, 1'b1, 3'd0, 8'd0,   8'hff);
      send_word(3'd1, 1'b1, 3'd1, 8'd255, 8'h00);
      send_word(3'd1, 1'b0, 3'd0, 8'd0,   8'h00);
      send_word(3'd2, 1'b0, 3'd3, 8'd255, 8'h55);
      send_word(3'd1, 1'b0, 3'd0, 8'd0,   8'h00);
      send_word(3'd3, 1'b1, 3'd3, 8'd128, 8'h5a);
      send_word(3'd1, 1'b0, 3'd1, 8'd255, 8'h00);
      send_word(3'd0, 1'b1, 3'd0, 8'd1,   8'h01);
      send_word(3'd6, 1'b0, 3'd2, 8'd2,   8'h02);
      send_word(3'd7, 1'b1, 3'd7, 8'd255, 8'hff);
      send_word(3'd5, 1'b1, 3'd2, 8'd7,   8'ha5);
      send_word(3'd5, 1'b0, 3'd4, 8'd0,   8'h00);
      send_word(3'd5, 1'b0, 3'd2, 8'd7,   8'h00);
      send_word(3'd4, 1'b0, 3'd3, 8'd64,  8'h00);
      stop_start();

      apply_setting(12, 5, 7, 7, 7, 7, 7);
      random_words(300, 0);
      apply_setting(3, 4, 2, 5, 7, 3, 2);
      random_words(280, 0);
      apply_setting(0, 7, 6, 6, 6, 6, 6);
      random_words(200, 0);
      apply_setting(15, 0, 2, 2, 2, 2, 2);
      random_words(60, 0);
      apply_setting(5, 5, $urandom_range(2, 7), 2, $urandom_range(2, 7), 3, 7);
      random_words(250, 1);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
